@@ hw/rtl/gchk_pkg.sv @@
// ----------------------------------------------------------------------------
// gchk_pkg
// Shared widths, register indexes, reset values and rounding helpers of the
// per-cell scalar Kalman height filter.
// ----------------------------------------------------------------------------
package gchk_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int SQ_W       = 32;
  localparam int CFG_ADDR_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_STATE_GAIN    = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_GAIN  = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_MEASURE_NOISE = CFG_ADDR_W'(3);

  localparam logic [VAL_W-1:0] CFG_RESET = VAL_W'(410);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = 58;
  localparam int DVD_W   = 63;
  localparam int DVS_W   = 54;
  localparam int QUO_W   = 32;

  typedef logic signed [MUL_P_W-1:0] prod_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quotient;
  } div_res_t;

  // divide by 2^s, round to nearest, ties away from zero
  function automatic prod_t rnd_shift(input prod_t v, input int unsigned s);
    prod_t h;
    h = prod_t'(1) <<< (s - 1);
    if (v < 0) begin
      return (v + h - prod_t'(1)) >>> s;
    end
    return (v + h) >>> s;
  endfunction

endpackage

@@ hw/rtl/gchk_meas_if.sv @@
// ----------------------------------------------------------------------------
// gchk_meas_if
// Measurement channel: one cell index pair with height and variance seed.
// ----------------------------------------------------------------------------
interface gchk_meas_if import gchk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_row;
  logic [IDX_W-1:0] cell_col;
  logic signed [VAL_W-1:0] meas_height;
  logic [VAL_W-1:0] meas_bias;

  modport source (output valid, cell_row, cell_col, meas_height, meas_bias, input ready);
  modport sink   (input valid, cell_row, cell_col, meas_height, meas_bias, output ready);
endinterface

@@ hw/rtl/gchk_est_if.sv @@
// ----------------------------------------------------------------------------
// gchk_est_if
// Estimate channel: updated height, variance, squared error, first-visit flag.
// ----------------------------------------------------------------------------
interface gchk_est_if import gchk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] est_height;
  logic [VAL_W-1:0]        est_variance;
  logic [SQ_W-1:0]         sq_error;
  logic                    first_visit;

  modport source (output valid, est_height, est_variance, sq_error, first_visit,
                  input ready);
  modport sink   (input valid, est_height, est_variance, sq_error, first_visit,
                  output ready);
endinterface

@@ hw/rtl/gchk_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gchk_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gchk_cfg_if import gchk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [VAL_W-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ hw/rtl/gchk_ram.sv @@
// ----------------------------------------------------------------------------
// gchk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gchk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gchk_mul.sv @@
// ----------------------------------------------------------------------------
// gchk_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module gchk_mul import gchk_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output prod_t                     prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

@@ hw/rtl/gchk_div.sv @@
// ----------------------------------------------------------------------------
// gchk_div
// Restoring divider, one quotient bit per cycle, with overflow detect for
// quotients of 2^32 and above.
// ----------------------------------------------------------------------------
module gchk_div import gchk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_res_t         res
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DVS_W-1:0] rem;
  logic [QUO_W-1:0] dlo;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic             ovf;
  logic [DVS_W:0]   trial;
  logic             take;

  assign trial = {rem, dlo[QUO_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ovf <= DVS_W'(dividend[DVD_W-1:QUO_W]) >= divisor;
        rem <= DVS_W'(dividend[DVD_W-1:QUO_W]);
        dlo <= dividend[QUO_W-1:0];
        quo <= '0;
        cnt <= CNT_W'(QUO_W);
        run <= 1'b1;
      end else if (run) begin
        rem <= take ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
        quo <= {quo[QUO_W-2:0], take};
        dlo <= {dlo[QUO_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done     = done;
  assign res.ovf      = ovf;
  assign res.quotient = quo;

endmodule

@@ hw/rtl/grid_cell_height_kalman_core.sv @@
// ----------------------------------------------------------------------------
// grid_cell_height_kalman_core
// Scalar Kalman height estimate and variance per grid cell, one shared
// multiplier and one serial divider stepped by a small sequencer.
//
//   channel | dir | payload
//   --------+-----+-----------------------------------------------------
//   cfg     | in  | addr, data (register write)
//   meas    | in  | cell_row, cell_col, meas_height, meas_bias
//   est     | out | est_height, est_variance, sq_error, first_visit
//
// Each measurement makes eleven passes through the shared multiplier and runs
// the one-bit-per-cycle divider for the gain.
// After reset the cell store is swept clear, one cell per cycle; meas is
// not ready during the sweep.
// A stalled est holds the finished transaction and the next measurement.
// ----------------------------------------------------------------------------
module grid_cell_height_kalman_core import gchk_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gchk_cfg_if.sink   cfg,
  gchk_meas_if.sink  meas,
  gchk_est_if.source est
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = 2 * VAL_W + 1;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_OP2, S_OP3, S_OP4, S_OP5, S_OP6, S_OP7,
    S_DEN, S_DIVGO, S_DIV, S_OP8, S_OP9, S_OP10, S_OP11, S_SIG, S_WRITE
  } state_t;

  state_t state;

  logic signed [VAL_W-1:0] a_g;
  logic signed [VAL_W-1:0] c_g;
  logic [VAL_W-1:0]        r_n;
  logic [VAL_W-1:0]        q_n;

  logic [AW-1:0]           clr_cnt;
  logic [AW-1:0]           addr;
  logic signed [VAL_W-1:0] z;
  logic [VAL_W-1:0]        bias;
  logic [VAL_W-1:0]        sig_prev;
  logic                    first;
  logic signed [19:0]      mb;
  logic [30:0]             aa;
  logic [30:0]             cc;
  logic [22:0]             sb;
  logic signed [22:0]      innov;
  logic                    num_neg;
  logic [37:0]             num_mag;
  logic [DVS_W-1:0]        den;
  logic signed [31:0]      k;
  logic signed [VAL_W-1:0] mu;
  logic [28:0]             tcl;
  logic [SQ_W-1:0]         sq;
  logic [VAL_W-1:0]        sig;

  logic [31:0]             row_w;
  logic [31:0]             col_w;
  logic [AW-1:0]           addr_c;

  logic                    ram_we;
  logic [AW-1:0]           ram_wa;
  logic [RW-1:0]           ram_wd;
  logic [RW-1:0]           ram_rd;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  prod_t                     prod;
  prod_t                     abs_p;
  prod_t                     r12;
  prod_t                     r24;
  prod_t                     mu_full;
  prod_t                     t_full;

  logic signed [VAL_W-1:0] mu_prev_c;
  logic [VAL_W-1:0]        sig_prev_c;
  logic signed [VAL_W:0]   diff;
  logic [DVD_W-1:0]        dividend;
  div_res_t                div_res;
  logic signed [31:0]      k_c;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_g <= CFG_RESET;
      c_g <= CFG_RESET;
      r_n <= CFG_RESET;
      q_n <= CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_STATE_GAIN:    a_g <= cfg.data;
        REG_MEASURE_GAIN:  c_g <= cfg.data;
        REG_PROCESS_NOISE: r_n <= cfg.data;
        REG_MEASURE_NOISE: q_n <= cfg.data;
        default: ;
      endcase
    end
  end

  // cell address, clamped to the grid
  always_comb begin
    row_w = 32'(meas.cell_row);
    col_w = 32'(meas.cell_col);
    if (row_w > 32'(GRID_ROWS - 1)) begin
      row_w = 32'(GRID_ROWS - 1);
    end
    if (col_w > 32'(GRID_COLS - 1)) begin
      col_w = 32'(GRID_COLS - 1);
    end
    addr_c = AW'(row_w * 32'(GRID_COLS) + col_w);
  end

  // cell store: {seen, estimate, variance}
  assign ram_we = (state == S_CLEAR) || (state == S_WRITE && (!est.valid || est.ready));
  assign ram_wa = (state == S_CLEAR) ? clr_cnt : addr;
  assign ram_wd = (state == S_CLEAR) ? '0 : {1'b1, mu, sig};

  gchk_ram #(.WIDTH(RW), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (addr),
    .rdata (ram_rd)
  );

  assign mu_prev_c  = ram_rd[RW-1] ? ram_rd[2*VAL_W-1:VAL_W] : z;
  assign sig_prev_c = ram_rd[RW-1] ? ram_rd[VAL_W-1:0] : bias;
  assign diff       = (VAL_W+1)'(z) - (VAL_W+1)'(mu);

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_LOAD: begin op_a = MUL_A_W'(mu_prev_c); op_b = MUL_B_W'(a_g); end
      S_OP2:  begin op_a = MUL_A_W'(a_g);       op_b = MUL_B_W'(a_g); end
      S_OP3:  begin op_a = MUL_A_W'(c_g);       op_b = MUL_B_W'(c_g); end
      S_OP4:  begin op_a = MUL_A_W'(aa);        op_b = MUL_B_W'(sig_prev); end
      S_OP5:  begin op_a = MUL_A_W'(mb);        op_b = MUL_B_W'(c_g); end
      S_OP6:  begin op_a = MUL_A_W'(sb);        op_b = MUL_B_W'(c_g); end
      S_OP7:  begin op_a = MUL_A_W'(cc);        op_b = MUL_B_W'(sb); end
      S_OP8:  begin op_a = MUL_A_W'(k);         op_b = MUL_B_W'(innov); end
      S_OP9:  begin op_a = MUL_A_W'(k);         op_b = MUL_B_W'(c_g); end
      S_OP10: begin op_a = MUL_A_W'(diff);      op_b = MUL_B_W'(diff); end
      S_OP11: begin op_a = MUL_A_W'(tcl);       op_b = MUL_B_W'(sb); end
      default: ;
    endcase
  end

  gchk_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign r12     = rnd_shift(prod, 12);
  assign r24     = rnd_shift(prod, 24);
  assign abs_p   = prod[MUL_P_W-1] ? -prod : prod;
  assign mu_full = MUL_P_W'(mb) + r12;
  assign t_full  = prod_t'(4096) - r12;

  assign dividend = DVD_W'({num_mag, 24'b0}) + DVD_W'(den >> 1);

  gchk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVGO),
    .dividend (dividend),
    .divisor  (den),
    .res      (div_res)
  );

  // saturate the gain to 32-bit signed
  always_comb begin
    if (den == '0) begin
      k_c = '0;
    end else if (num_neg) begin
      if (div_res.ovf || div_res.quotient > 32'h8000_0000) begin
        k_c = 32'sh8000_0000;
      end else begin
        k_c = -$signed(div_res.quotient);
      end
    end else if (div_res.ovf || div_res.quotient[31]) begin
      k_c = 32'sh7fff_ffff;
    end else begin
      k_c = $signed(div_res.quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      meas.ready <= 1'b0;
      est.valid <= 1'b0;
    end else begin
      if (est.valid && est.ready && state != S_WRITE) begin
        est.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_CELL) begin
            state      <= S_IDLE;
            meas.ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (meas.valid) begin
            addr       <= addr_c;
            z          <= meas.meas_height;
            bias       <= meas.meas_bias;
            meas.ready <= 1'b0;
            state      <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          first    <= !ram_rd[RW-1];
          sig_prev <= sig_prev_c;
          state    <= S_OP2;
        end
        S_OP2: begin
          mb    <= r12[19:0];
          state <= S_OP3;
        end
        S_OP3: begin
          aa    <= prod[30:0];
          state <= S_OP4;
        end
        S_OP4: begin
          cc    <= prod[30:0];
          state <= S_OP5;
        end
        S_OP5: begin
          sb    <= r24[22:0] + 23'(r_n);
          state <= S_OP6;
        end
        S_OP6: begin
          innov <= 23'(z) - r12[22:0];
          state <= S_OP7;
        end
        S_OP7: begin
          num_neg <= prod[MUL_P_W-1];
          num_mag <= abs_p[37:0];
          state   <= S_DEN;
        end
        S_DEN: begin
          den   <= prod[DVS_W-1:0] + (DVS_W'(q_n) << 24);
          state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: begin
          if (div_res.done) begin
            k     <= k_c;
            state <= S_OP8;
          end
        end
        S_OP8: state <= S_OP9;
        S_OP9: begin
          if (mu_full < -prod_t'(32768)) begin
            mu <= 16'sh8000;
          end else if (mu_full > prod_t'(32767)) begin
            mu <= 16'sh7fff;
          end else begin
            mu <= mu_full[VAL_W-1:0];
          end
          state <= S_OP10;
        end
        S_OP10: begin
          if (t_full < 0) begin
            tcl <= '0;
          end else if (t_full > prod_t'(1 << 28)) begin
            tcl <= 29'(1 << 28);
          end else begin
            tcl <= t_full[28:0];
          end
          state <= S_OP11;
        end
        S_OP11: begin
          sq    <= (prod > prod_t'(33'h0_ffff_ffff)) ? '1 : prod[SQ_W-1:0];
          state <= S_SIG;
        end
        S_SIG: begin
          if (r12 < 0) begin
            sig <= '0;
          end else if (r12 > prod_t'(65535)) begin
            sig <= '1;
          end else begin
            sig <= r12[VAL_W-1:0];
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!est.valid || est.ready) begin
            est.valid        <= 1'b1;
            est.est_height   <= mu;
            est.est_variance <= sig;
            est.sq_error     <= sq;
            est.first_visit  <= first;
            meas.ready       <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
